// ===== rtl/malu_pkg.sv =====
// malu_pkg: shared item type, operation codes and status bit positions for the misc alu unit
// no dependencies
`default_nettype none
package malu_pkg;

    // operation codes
    localparam logic [3:0] FN_XCN  = 4'd0;
    localparam logic [3:0] FN_DAA  = 4'd1;
    localparam logic [3:0] FN_DAS  = 4'd2;
    localparam logic [3:0] FN_MUL  = 4'd3;
    localparam logic [3:0] FN_DIV  = 4'd4;
    localparam logic [3:0] FN_CLRC = 4'd5;
    localparam logic [3:0] FN_SETC = 4'd6;
    localparam logic [3:0] FN_NOTC = 4'd7;
    localparam logic [3:0] FN_CLRV = 4'd8;
    localparam logic [3:0] FN_CLRP = 4'd9;
    localparam logic [3:0] FN_SETP = 4'd10;
    localparam logic [3:0] FN_EI   = 4'd11;
    localparam logic [3:0] FN_DI   = 4'd12;

    // status bit positions
    localparam int B_N = 7;
    localparam int B_V = 6;
    localparam int B_P = 5;
    localparam int B_H = 3;
    localparam int B_I = 2;
    localparam int B_Z = 1;
    localparam int B_C = 0;

    // number of quotient bits, one divider cell each
    localparam int QBITS = 9;

    // item travelling down the pipe
    typedef struct packed {
        logic       is_div;
        logic       ovf;
        logic [7:0] xv;
        logic [8:0] divisor;
        logic [8:0] rem;
        logic [8:0] dlow;
        logic [8:0] quo;
        logic [7:0] acc;
        logic [7:0] yr;
        logic [7:0] st;
    } t_item;

endpackage
`default_nettype wire

// ===== rtl/malu_prep.sv =====
// malu_prep: front stage, does all non-divide operations and sets up the divide
// depends on malu_pkg
`default_nettype none
module malu_prep (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire  [3:0]      i_func,
    input  wire  [7:0]      i_acc,
    input  wire  [7:0]      i_x,
    input  wire  [7:0]      i_y,
    input  wire  [7:0]      i_st,
    input  wire             i_ready,
    output logic            o_valid,
    output malu_pkg::t_item o_item
);

    logic            r_valid;
    malu_pkg::t_item r_item;
    malu_pkg::t_item n_item;

    logic [7:0]  a1, a2, st1, st2;
    logic [15:0] pair, prod, dvd;
    logic        ovf;

    assign o_ready = !r_valid || i_ready;

    // operation logic
    always_comb begin
        n_item         = '0;
        n_item.acc     = i_acc;
        n_item.yr      = i_y;
        n_item.st      = i_st;
        n_item.xv      = i_x;
        a1             = i_acc;
        a2             = i_acc;
        st1            = i_st;
        st2            = i_st;
        pair           = {i_y, i_acc};
        prod           = i_y * i_acc;
        ovf            = {1'b0, i_y} >= {i_x, 1'b0};
        dvd            = ovf ? (pair - {i_x[6:0], 9'd0}) : pair;
        case (i_func)
            malu_pkg::FN_XCN: begin
                n_item.acc = {i_acc[3:0], i_acc[7:4]};
                n_item.st[malu_pkg::B_N] = i_acc[3];
                n_item.st[malu_pkg::B_Z] = (i_acc == 8'd0);
            end
            malu_pkg::FN_DAA: begin
                if (i_st[malu_pkg::B_C] || i_acc > 8'h99) begin
                    a1 = i_acc + 8'h60;
                    st1[malu_pkg::B_C] = 1'b1;
                end
                if (st1[malu_pkg::B_H] || a1[3:0] > 4'h9) begin
                    a2 = a1 + 8'h06;
                end else begin
                    a2 = a1;
                end
                n_item.acc = a2;
                st2 = st1;
                st2[malu_pkg::B_N] = a2[7];
                st2[malu_pkg::B_Z] = (a2 == 8'd0);
                n_item.st = st2;
            end
            malu_pkg::FN_DAS: begin
                if (!i_st[malu_pkg::B_C] || i_acc > 8'h99) begin
                    a1 = i_acc - 8'h60;
                    st1[malu_pkg::B_C] = 1'b0;
                end
                if (!st1[malu_pkg::B_H] || a1[3:0] > 4'h9) begin
                    a2 = a1 - 8'h06;
                end else begin
                    a2 = a1;
                end
                n_item.acc = a2;
                st2 = st1;
                st2[malu_pkg::B_N] = a2[7];
                st2[malu_pkg::B_Z] = (a2 == 8'd0);
                n_item.st = st2;
            end
            malu_pkg::FN_MUL: begin
                n_item.acc = prod[7:0];
                n_item.yr  = prod[15:8];
                n_item.st[malu_pkg::B_N] = prod[15];
                n_item.st[malu_pkg::B_Z] = (prod[15:8] == 8'd0);
            end
            malu_pkg::FN_DIV: begin
                n_item.is_div  = 1'b1;
                n_item.ovf     = ovf;
                n_item.divisor = ovf ? (9'd256 - {1'b0, i_x}) : {1'b0, i_x};
                n_item.rem     = {2'b00, dvd[15:9]};
                n_item.dlow    = dvd[8:0];
                n_item.st[malu_pkg::B_V] = (i_y >= i_x);
                n_item.st[malu_pkg::B_H] = (i_y[3:0] >= i_x[3:0]);
            end
            malu_pkg::FN_CLRC: n_item.st[malu_pkg::B_C] = 1'b0;
            malu_pkg::FN_SETC: n_item.st[malu_pkg::B_C] = 1'b1;
            malu_pkg::FN_NOTC: n_item.st[malu_pkg::B_C] = !i_st[malu_pkg::B_C];
            malu_pkg::FN_CLRV: begin
                n_item.st[malu_pkg::B_V] = 1'b0;
                n_item.st[malu_pkg::B_H] = 1'b0;
            end
            malu_pkg::FN_CLRP: n_item.st[malu_pkg::B_P] = 1'b0;
            malu_pkg::FN_SETP: n_item.st[malu_pkg::B_P] = 1'b1;
            malu_pkg::FN_EI:   n_item.st[malu_pkg::B_I] = 1'b1;
            malu_pkg::FN_DI:   n_item.st[malu_pkg::B_I] = 1'b0;
            default: ;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/malu_div_cell.sv =====
// malu_div_cell: one restoring divide step, produces one quotient bit per item
// depends on malu_pkg
`default_nettype none
module malu_div_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  malu_pkg::t_item i_item,
    input  wire             i_ready,
    output logic            o_valid,
    output malu_pkg::t_item o_item
);

    logic            r_valid;
    malu_pkg::t_item r_item;
    malu_pkg::t_item n_item;
    logic [9:0]      trial;
    logic            ge;

    assign o_ready = !r_valid || i_ready;

    // shift in next dividend bit, subtract when it fits
    always_comb begin
        n_item = i_item;
        trial  = {i_item.rem, i_item.dlow[8]};
        ge     = trial >= {1'b0, i_item.divisor};
        if (i_item.is_div) begin
            n_item.rem  = ge ? 9'(trial - {1'b0, i_item.divisor}) : trial[8:0];
            n_item.dlow = {i_item.dlow[7:0], 1'b0};
            n_item.quo  = {i_item.quo[7:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/malu_fin.sv =====
// malu_fin: final stage, folds the divide result and holds the output register
// depends on malu_pkg
`default_nettype none
module malu_fin (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  malu_pkg::t_item i_item,
    input  wire             i_ready,
    output logic            o_valid,
    output logic [7:0]      o_acc,
    output logic [7:0]      o_y,
    output logic [7:0]      o_st
);

    logic       r_valid;
    logic [7:0] r_acc, r_y, r_st;
    logic [7:0] n_acc, n_y, n_st;

    assign o_ready = !r_valid || i_ready;

    // overflow case maps quotient and remainder to the odd chip values
    always_comb begin
        n_acc = i_item.acc;
        n_y   = i_item.yr;
        n_st  = i_item.st;
        if (i_item.is_div) begin
            n_acc = i_item.ovf ? (8'hFF - i_item.quo[7:0]) : i_item.quo[7:0];
            n_y   = i_item.ovf ? (i_item.xv + i_item.rem[7:0]) : i_item.rem[7:0];
            n_st[malu_pkg::B_N] = n_acc[7];
            n_st[malu_pkg::B_Z] = (n_acc == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc <= n_acc;
            r_y   <= n_y;
            r_st  <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_y     = r_y;
    assign o_st    = r_st;

endmodule
`default_nettype wire

// ===== rtl/misc_alu_ops_unit.sv =====
// misc_alu_ops_unit: top level, front stage, divider cell chain, output stage
// depends on malu_pkg, malu_prep, malu_div_cell, malu_fin
//
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_func i_acc_in i_xreg_in i_yreg_in i_status_in
//  out     | o_valid | i_stall | o_acc_out o_yreg_out o_status_out
//
// one item per cycle sustained while the output is not stalled; every operation passes all stages
// the divide is worked out by the nine divider cells, one quotient bit per cell
// each stage moves on when the next one is empty or moving, so bubbles close up
// while the output is stalled; o_stall rises only when the front stage is held
// reset is synchronous and empties all stages
`default_nettype none
module misc_alu_ops_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [3:0] i_func,
    input  wire  [7:0] i_acc_in,
    input  wire  [7:0] i_xreg_in,
    input  wire  [7:0] i_yreg_in,
    input  wire  [7:0] i_status_in,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_yreg_out,
    output logic [7:0] o_status_out
);

    localparam int N = malu_pkg::QBITS;

    logic            v   [0:N];
    logic            rdy [0:N];
    malu_pkg::t_item itm [0:N];
    logic            prep_ready, fin_ready;

    // front stage
    malu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (prep_ready),
        .i_func  (i_func),
        .i_acc   (i_acc_in),
        .i_x     (i_xreg_in),
        .i_y     (i_yreg_in),
        .i_st    (i_status_in),
        .i_ready (rdy[0]),
        .o_valid (v[0]),
        .o_item  (itm[0])
    );

    // divider cell chain
    for (genvar k = 0; k < N; k++) begin : g_cell
        malu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_item  (itm[k]),
            .i_ready (rdy[k+1]),
            .o_valid (v[k+1]),
            .o_item  (itm[k+1])
        );
    end

    assign rdy[N] = fin_ready;

    // output stage
    malu_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[N]),
        .o_ready (fin_ready),
        .i_item  (itm[N]),
        .i_ready (!i_stall),
        .o_valid (o_valid),
        .o_acc   (o_acc_out),
        .o_y     (o_yreg_out),
        .o_st    (o_status_out)
    );

    assign o_stall = !prep_ready;

`ifndef NO_ASSERTIONS
    // an empty front stage never pushes back
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !v[0] |-> !o_stall) else $error("stall with empty front stage");

    // remainder ends below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[N] && itm[N].is_div) |-> (itm[N].rem < itm[N].divisor))
        else $error("divide remainder not below divisor");

    // overflow quotient fits in eight bits
    a_ovf_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[N] && itm[N].is_div && itm[N].ovf) |-> !itm[N].quo[8])
        else $error("overflow quotient too wide");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_misc_alu_ops_unit.sv =====
// tb_misc_alu_ops_unit: self-checking testbench for the misc alu unit
// drives random and directed items, predicts each result, checks in order
// depends on malu_pkg and misc_alu_ops_unit
`timescale 1ns / 1ps
module tb_misc_alu_ops_unit;

    typedef struct {
        logic [7:0] acc;
        logic [7:0] yr;
        logic [7:0] st;
    } t_alu_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [3:0] i_func = '0;
    logic [7:0] i_acc_in = '0;
    logic [7:0] i_xreg_in = '0;
    logic [7:0] i_yreg_in = '0;
    logic [7:0] i_status_in = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_acc_out;
    logic [7:0] o_yreg_out;
    logic [7:0] o_status_out;

    t_alu_res   expected_q[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_off = 1'b0;

    misc_alu_ops_unit dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // set n and z from a byte
    function automatic logic [7:0] set_nz(logic [7:0] st, logic [7:0] v);
        st[malu_pkg::B_N] = v[7];
        st[malu_pkg::B_Z] = (v == 8'd0);
        return st;
    endfunction

    // compute the expected registers for one operation
    function automatic t_alu_res alu_predict(logic [3:0] fn, logic [7:0] a, logic [7:0] x,
                                             logic [7:0] y, logic [7:0] st);
        t_alu_res    r;
        logic [15:0] pair;
        logic [15:0] rest;
        logic [15:0] den;
        logic [15:0] prod;
        pair = {y, a};
        case (fn)
            malu_pkg::FN_XCN: begin
                a = {a[3:0], a[7:4]};
                st = set_nz(st, a);
            end
            malu_pkg::FN_DAA: begin
                if (st[malu_pkg::B_C] || a > 8'h99) begin
                    a = a + 8'h60;
                    st[malu_pkg::B_C] = 1'b1;
                end
                if (st[malu_pkg::B_H] || a[3:0] > 4'h9) a = a + 8'h06;
                st = set_nz(st, a);
            end
            malu_pkg::FN_DAS: begin
                if (!st[malu_pkg::B_C] || a > 8'h99) begin
                    a = a - 8'h60;
                    st[malu_pkg::B_C] = 1'b0;
                end
                if (!st[malu_pkg::B_H] || a[3:0] > 4'h9) a = a - 8'h06;
                st = set_nz(st, a);
            end
            malu_pkg::FN_MUL: begin
                prod = y * a;
                a = prod[7:0];
                y = prod[15:8];
                st = set_nz(st, y);
            end
            malu_pkg::FN_DIV: begin
                st[malu_pkg::B_V] = (y >= x);
                st[malu_pkg::B_H] = (y[3:0] >= x[3:0]);
                if ({1'b0, y} < {x, 1'b0}) begin
                    a = 8'(pair / x);
                    y = 8'(pair % x);
                end else begin
                    // overflow branch only reached with x below 128
                    rest = pair - {x[6:0], 9'd0};
                    den = 16'd256 - x;
                    a = 8'(16'd255 - rest / den);
                    y = 8'(x + rest % den);
                end
                st = set_nz(st, a);
            end
            malu_pkg::FN_CLRC: st[malu_pkg::B_C] = 1'b0;
            malu_pkg::FN_SETC: st[malu_pkg::B_C] = 1'b1;
            malu_pkg::FN_NOTC: st[malu_pkg::B_C] = ~st[malu_pkg::B_C];
            malu_pkg::FN_CLRV: begin
                st[malu_pkg::B_V] = 1'b0;
                st[malu_pkg::B_H] = 1'b0;
            end
            malu_pkg::FN_CLRP: st[malu_pkg::B_P] = 1'b0;
            malu_pkg::FN_SETP: st[malu_pkg::B_P] = 1'b1;
            malu_pkg::FN_EI:   st[malu_pkg::B_I] = 1'b1;
            malu_pkg::FN_DI:   st[malu_pkg::B_I] = 1'b0;
            default: ;
        endcase
        r.acc = a;
        r.yr = y;
        r.st = st;
        return r;
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(logic [3:0] fn, logic [7:0] a, logic [7:0] x,
                             logic [7:0] y, logic [7:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_acc_in <= a;
        i_xreg_in <= x;
        i_yreg_in <= y;
        i_status_in <= st;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(alu_predict(fn, a, x, y, st));
    endtask

    // random item; divide is weighted up and steered toward both branches
    task automatic send_random();
        logic [3:0] fn;
        logic [7:0] x;
        logic [7:0] y;
        fn = ($urandom_range(3) == 0) ? malu_pkg::FN_DIV : 4'($urandom);
        x = 8'($urandom);
        y = 8'($urandom);
        if (fn == malu_pkg::FN_DIV && $urandom_range(1))
            y = 8'($urandom_range(0, 255)) % (x | 8'd1);
        if (fn == malu_pkg::FN_DIV && $urandom_range(9) == 0)
            x = 8'($urandom_range(1)) ? 8'd0 : 8'd255;
        send_item(fn, 8'($urandom), x, y, 8'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    // extremes of every field and each operation
    task automatic test_directed();
        for (int f = 0; f < 16; f++) send_item(4'(f), 8'hA5, 8'h5A, 8'hC3, 8'h00);
        send_item(malu_pkg::FN_DAA, 8'h9A, 8'h00, 8'h00, 8'h00);
        send_item(malu_pkg::FN_DAA, 8'h0A, 8'h00, 8'h00, 8'hFF);
        send_item(malu_pkg::FN_DAS, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_item(malu_pkg::FN_DIV, 8'hFF, 8'h00, 8'hFF, 8'hFF); // zero divisor
        send_item(malu_pkg::FN_DIV, 8'hFF, 8'h01, 8'h01, 8'h00); // quotient overflow
        send_item(malu_pkg::FN_DIV, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(malu_pkg::FN_DIV, 8'hFF, 8'h80, 8'hFF, 8'h00);
        send_item(malu_pkg::FN_MUL, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(malu_pkg::FN_MUL, 8'h00, 8'h00, 8'hFF, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_random();
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        repeat (60) send_random();
        wait_drained();
    endtask

    // receiver stall and long hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
            repeat (80) @(posedge i_clk);
            i_stall <= 1'b0;
            hold_off <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // check each accepted result
    always @(posedge i_clk) begin
        t_alu_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result acc=%h y=%h st=%h", $time,
                         o_acc_out, o_yreg_out, o_status_out);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_acc_out !== e.acc || o_yreg_out !== e.yr || o_status_out !== e.st) begin
                    $display("%0t: mismatch expected acc=%h y=%h st=%h actual acc=%h y=%h st=%h",
                             $time, e.acc, e.yr, e.st, o_acc_out, o_yreg_out, o_status_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 300);
        test_random_phase(58, 0, 250);
        test_random_phase(0, 58, 250);
        test_random_phase(12, 12, 300);
        test_backpressure();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== misc_alu_ops_unit.f =====
rtl/malu_pkg.sv
rtl/malu_prep.sv
rtl/malu_div_cell.sv
rtl/malu_fin.sv
rtl/misc_alu_ops_unit.sv
sim/tb_misc_alu_ops_unit.sv
